/* rtl/npcm_pkg.sv */
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants for the nearest palette colour match unit.
// ----------------------------------------------------------------------------
package npcm_pkg;

  localparam int MaxColoursDefault = 256;
  localparam int DistW = 20;
  localparam logic [DistW-1:0] HalfMax = 20'hFFFFF;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_FINALIZE = 2'd1,
    OP_MATCH    = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  // match state handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             have;
    logic             done;
    logic [DistW-1:0] run_min;
    logic [7:0]       best;
    logic [31:0]      colour;
  } token_t;

  // channel difference squared, then weighted sum
  function automatic logic [DistW-1:0] colour_dist(input logic [31:0] a,
                                                   input logic [31:0] b);
    logic [8:0]  db;
    logic [8:0]  dg;
    logic [8:0]  dr;
    logic [15:0] sb;
    logic [15:0] sg;
    logic [15:0] sr;
    logic [DistW-1:0] sum;
    db = (a[31:24] > b[31:24]) ? {1'b0, a[31:24] - b[31:24]} : {1'b0, b[31:24] - a[31:24]};
    dg = (a[23:16] > b[23:16]) ? {1'b0, a[23:16] - b[23:16]} : {1'b0, b[23:16] - a[23:16]};
    dr = (a[15:8] > b[15:8]) ? {1'b0, a[15:8] - b[15:8]} : {1'b0, b[15:8] - a[15:8]};
    sb = db[7:0] * db[7:0];
    sg = dg[7:0] * dg[7:0];
    sr = dr[7:0] * dr[7:0];
    sum = {4'd0, sb} + DistW'(sg) * DistW'(10) + DistW'(sr) * DistW'(3);
    return sum;
  endfunction

endpackage

/* rtl/nearest_palette_colour_match_unit.sv */
// ----------------------------------------------------------------------------
// nearest_palette_colour_match_unit
// Weighted RGB nearest palette search over a row of slot cells.
// ----------------------------------------------------------------------------
// Load: writes colour_word into slot entry_index. Match: a token walks all
// MAX_COLOURS cells, one per cycle; the result strobes once it leaves the last
// cell. Finalize: palette rotates one cell per cycle over the N entries in use.
// busy is high while a finalize or match runs; results strobe for one cycle.
// rst clears control state and the token chain and sets palette_size to 256;
// the palette is undefined until loaded.
module nearest_palette_colour_match_unit import npcm_pkg::*; #(
  parameter int MAX_COLOURS = MaxColoursDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [7:0]  entry_index,
  input  logic [31:0] colour_word,
  input  logic        want_index,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  output logic        result_valid,
  output logic [31:0] match_value,
  output logic [7:0]  best_slot
);

  localparam int CW = $clog2(MAX_COLOURS + 1);

  typedef enum logic [1:0] {S_IDLE, S_FIN, S_MATCH} state_t;

  state_t state;
  logic [8:0] palette_size;
  logic [CW-1:0] n_use;
  logic [CW-1:0] step_cnt;
  logic [31:0] probe;
  logic want;
  logic go;
  logic accept;
  logic fin_init;
  logic fin_step;
  logic half_wr;
  logic [31:0] col [MAX_COLOURS];
  logic [31:0] rot [MAX_COLOURS];
  token_t tok [MAX_COLOURS];
  token_t head;
  token_t tail;

  always_comb begin
    if (palette_size == 9'd0) begin
      n_use = CW'(1);
    end else if (palette_size > 9'(MAX_COLOURS)) begin
      n_use = CW'(MAX_COLOURS);
    end else begin
      n_use = CW'(palette_size);
    end
  end

  assign accept = start && !busy;
  assign fin_init = accept && opcode == OP_FINALIZE;
  assign fin_step = state == S_FIN && step_cnt != n_use - CW'(1);
  assign half_wr = state == S_FIN && step_cnt == n_use - CW'(1);

  always_comb begin
    head = '0;
    head.valid = go;
    head.run_min = HalfMax;
  end

  for (genvar k = 0; k < MAX_COLOURS; k++) begin : g_cell
    token_t tok_in;
    if (k == 0) begin : g_head
      assign tok_in = head;
    end else begin : g_link
      assign tok_in = tok[k - 1];
    end
    npcm_cell #(
      .IDX(k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .in_use      (CW'(k) < n_use),
      .is_last     (CW'(k) == n_use - CW'(1)),
      .load_en     (accept && opcode == OP_LOAD && 32'(entry_index) == 32'(k)),
      .load_colour (colour_word),
      .fin_init    (fin_init),
      .fin_step    (fin_step),
      .half_wr     (half_wr),
      .nbr_colour  (col[(k + 1) % MAX_COLOURS]),
      .first_colour(col[0]),
      .nbr_rot     (rot[(k + 1) % MAX_COLOURS]),
      .first_rot   (rot[0]),
      .probe       (probe),
      .tok_in      (tok_in),
      .colour      (col[k]),
      .rot         (rot[k]),
      .tok_out     (tok[k])
    );
  end

  assign tail = tok[MAX_COLOURS - 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      palette_size <= 9'd256;
      result_valid <= 1'b0;
      go <= 1'b0;
    end else begin
      result_valid <= (state == S_MATCH) && tail.valid;
      go <= (state == S_IDLE) && start && opcode == OP_MATCH;
      if (cfg_we) begin
        palette_size <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            probe <= colour_word;
            want <= want_index;
            step_cnt <= '0;
            if (opcode == OP_FINALIZE) begin
              state <= S_FIN;
            end else if (opcode == OP_MATCH) begin
              state <= S_MATCH;
            end
          end
        end
        S_FIN: begin
          if (half_wr) begin
            state <= S_IDLE;
          end else begin
            step_cnt <= step_cnt + CW'(1);
          end
        end
        S_MATCH: begin
          if (tail.valid) begin
            match_value <= want ? 32'(tail.best) : tail.colour;
            best_slot <= tail.best;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/npcm_cell.sv */
// ----------------------------------------------------------------------------
// npcm_cell
// One palette slot: holds its colour and half-distance, updates the match
// token passing through, and rotates palette colours during a finalize.
// ----------------------------------------------------------------------------
module npcm_cell import npcm_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_use,
  input  logic        is_last,
  input  logic        load_en,
  input  logic [31:0] load_colour,
  input  logic        fin_init,
  input  logic        fin_step,
  input  logic        half_wr,
  input  logic [31:0] nbr_colour,
  input  logic [31:0] first_colour,
  input  logic [31:0] nbr_rot,
  input  logic [31:0] first_rot,
  input  logic [31:0] probe,
  input  token_t      tok_in,
  output logic [31:0] colour,
  output logic [31:0] rot,
  output token_t      tok_out
);

  logic [DistW-1:0] half;
  logic [DistW-1:0] fmin;
  logic [DistW-1:0] probe_dist;
  logic [DistW-1:0] pair_half;
  logic             take;
  token_t           tok_next;

  assign probe_dist = colour_dist(fin_step ? rot : probe, colour);
  assign pair_half = probe_dist >> 1;
  assign take = !tok_in.have || probe_dist < tok_in.run_min;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && in_use && !tok_in.done && take) begin
      tok_next.have = 1'b1;
      tok_next.run_min = probe_dist;
      tok_next.best = 8'(IDX);
      tok_next.colour = colour;
      tok_next.done = probe_dist < half;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      colour <= load_colour;
    end
    if (fin_init) begin
      rot <= is_last ? first_colour : nbr_colour;
      fmin <= HalfMax;
    end else if (fin_step) begin
      rot <= is_last ? first_rot : nbr_rot;
      if (pair_half < fmin) begin
        fmin <= pair_half;
      end
    end
    if (half_wr && in_use) begin
      half <= fmin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

/* rtl/npcm_checker.sv */
// ----------------------------------------------------------------------------
// npcm_checker
// Port-level checks for the nearest palette colour match unit.
// ----------------------------------------------------------------------------
module npcm_checker import npcm_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] opcode,
  input logic       result_valid
);

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_LOAD |=> !busy)
    else $error("load left unit busy");

  a_match_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_MATCH |=> busy)
    else $error("match did not start");

  a_res_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  a_res_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a running match");

endmodule

bind nearest_palette_colour_match_unit npcm_checker u_npcm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
  .result_valid(result_valid)
);
